### rtl/lppi_pkg.sv
// Shared types and constants for the laser path point interpolator.
// Holds the channel payload structs and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package lppi_pkg;

	// Insert count limit and derived arithmetic widths.
	localparam int MAX_INSERT   = 63;
	localparam int CNT_W        = 6;
	localparam int DIV_W        = 22;
	localparam int SQRT_W       = 34;
	localparam int SQRT_STEPS   = 17;
	localparam int DIV_STEPS    = 22;
	localparam int STEP_W       = 5;
	localparam int NUM_FIELDS   = 6;
	localparam int FIELD_W      = 3;

	// Configuration register indexes.
	localparam logic [7:0] CFG_MAX_SEGMENT_LENGTH = 8'd0;
	localparam logic [7:0] CFG_EASING_MODE        = 8'd1;

	// Easing mode codes.
	localparam logic [1:0] EASE_LINEAR    = 2'd0;
	localparam logic [1:0] EASE_QUADRATIC = 2'd1;
	localparam logic [1:0] EASE_QUARTIC   = 2'd2;

	// Field order used by the interpolation sequence.
	localparam logic [FIELD_W-1:0] FLD_X         = 3'd0;
	localparam logic [FIELD_W-1:0] FLD_Y         = 3'd1;
	localparam logic [FIELD_W-1:0] FLD_RED       = 3'd2;
	localparam logic [FIELD_W-1:0] FLD_GREEN     = 3'd3;
	localparam logic [FIELD_W-1:0] FLD_BLUE      = 3'd4;
	localparam logic [FIELD_W-1:0] FLD_INTENSITY = 3'd5;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         intensity;
		logic               frame_start;
	} point_in_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic [7:0]         out_red;
		logic [7:0]         out_green;
		logic [7:0]         out_blue;
		logic [7:0]         out_intensity;
		logic               is_inserted;
		logic               last_of_run;
	} point_out_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_SQX,
		OP_SQY,
		OP_SQRT_LOAD,
		OP_SQRT_STEP,
		OP_DIV_LOAD_CNT,
		OP_DIV_STEP,
		OP_SET_CNT,
		OP_DIV_LOAD_T,
		OP_EASE1,
		OP_EASE2,
		OP_LERP,
		OP_EMIT_INS,
		OP_EMIT_PASS
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [FIELD_W-1:0] field;
		logic [CNT_W-1:0]   pt;
	} cmd_t;

	typedef struct packed {
		logic             go;
		logic             gap;
		logic             slot_free;
		logic             dup;
		logic [CNT_W-1:0] count;
	} stat_t;

endpackage

### rtl/lppi_dp.sv
// Datapath of the laser path point interpolator: registers, distance, square root,
// shared serial divider, easing and field interpolation, output register.
// Depends on lppi_pkg.
`timescale 1ns / 1ps

module lppi_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  lppi_pkg::point_in_t in_data,
	output lppi_pkg::point_out_t out_data,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  lppi_pkg::cmd_t      cmd,
	output lppi_pkg::stat_t     status
);

	logic [15:0] msl_q;
	logic [1:0]  mode_q;

	lppi_pkg::point_in_t cur_q;
	logic        active_q;
	logic        go_q;
	logic [15:0] prev_x_q, prev_y_q;
	logic [7:0]  prev_r_q, prev_g_q, prev_b_q, prev_i_q;

	logic [32:0] acc_q;
	logic [31:0] mm_q;
	logic [lppi_pkg::SQRT_W-1:0] sq_v_q, sq_r_q, sq_bit_q;
	logic [15:0] rem_q;
	logic [lppi_pkg::DIV_W-1:0] quo_q;
	logic [15:0] div_d_q;
	logic [lppi_pkg::CNT_W-1:0] count_q;
	logic [31:0] esq_q;
	logic [16:0] e_q;
	logic [15:0] p_q [lppi_pkg::NUM_FIELDS];
	logic        out_valid_q;
	lppi_pkg::point_out_t out_q;

	// Configuration writes are always taken; unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msl_q  <= 16'd1024;
			mode_q <= lppi_pkg::EASE_LINEAR;
		end else if (cfg_valid) begin
			if (cfg_index == lppi_pkg::CFG_MAX_SEGMENT_LENGTH) begin
				msl_q <= cfg_data;
			end else if (cfg_index == lppi_pkg::CFG_EASING_MODE) begin
				mode_q <= cfg_data[1:0];
			end
		end
	end

	// Absolute coordinate differences to the previous point.
	logic signed [16:0] dx, dy;
	logic [15:0] ax, ay;
	assign dx = 17'(signed'(cur_q.pos_x)) - 17'(signed'(prev_x_q));
	assign dy = 17'(signed'(cur_q.pos_y)) - 17'(signed'(prev_y_q));
	assign ax = dx[16] ? 16'(-dx) : dx[15:0];
	assign ay = dy[16] ? 16'(-dy) : dy[15:0];

	// One digit of the square root per step.
	logic [lppi_pkg::SQRT_W-1:0] sq_sum;
	assign sq_sum = sq_r_q + sq_bit_q;

	// One quotient bit of the restoring divider per step.
	logic [16:0] div_shift, div_sub;
	logic        div_ge;
	assign div_shift = {rem_q, quo_q[lppi_pkg::DIV_W-1]};
	assign div_ge    = div_shift >= {1'b0, div_d_q};
	assign div_sub   = div_shift - {1'b0, div_d_q};

	// Easing: fold t about one half, square, then square again for quartic.
	logic [15:0] t_val, u_val;
	logic [63:0] e4;
	logic [16:0] e_quad, e_quart, e_next;
	assign t_val   = quo_q[15:0];
	assign u_val   = t_val[15] ? 16'(17'h10000 - {1'b0, t_val}) : t_val;
	assign e4      = 64'(esq_q) * 64'(esq_q);
	assign e_quad  = t_val[15] ? 17'(17'h10000 - 17'(esq_q >> 15)) : 17'(esq_q >> 15);
	assign e_quart = t_val[15] ? 17'(17'h10000 - 17'(e4 >> 45)) : 17'(e4 >> 45);

	always_comb begin
		unique case (mode_q)
			lppi_pkg::EASE_QUADRATIC: e_next = e_quad;
			lppi_pkg::EASE_QUARTIC:   e_next = e_quart;
			default:                  e_next = {1'b0, t_val};
		endcase
	end

	// Interpolation of one field per cycle as a + (b - a) * e.
	logic [15:0] la, lb;
	logic        is_coord;
	always_comb begin
		unique case (cmd.field)
			lppi_pkg::FLD_X: begin
				la = prev_x_q ^ 16'h8000;
				lb = cur_q.pos_x ^ 16'h8000;
			end
			lppi_pkg::FLD_Y: begin
				la = prev_y_q ^ 16'h8000;
				lb = cur_q.pos_y ^ 16'h8000;
			end
			lppi_pkg::FLD_RED: begin
				la = {8'd0, prev_r_q};
				lb = {8'd0, cur_q.red};
			end
			lppi_pkg::FLD_GREEN: begin
				la = {8'd0, prev_g_q};
				lb = {8'd0, cur_q.green};
			end
			lppi_pkg::FLD_BLUE: begin
				la = {8'd0, prev_b_q};
				lb = {8'd0, cur_q.blue};
			end
			default: begin
				la = {8'd0, prev_i_q};
				lb = {8'd0, cur_q.intensity};
			end
		endcase
	end
	assign is_coord = (cmd.field == lppi_pkg::FLD_X) || (cmd.field == lppi_pkg::FLD_Y);

	logic signed [16:0] ldiff;
	logic signed [35:0] lprod, lacc;
	logic [15:0] lres;
	assign ldiff = signed'({1'b0, lb}) - signed'({1'b0, la});
	assign lprod = 36'(ldiff * signed'({1'b0, e_q}));
	assign lacc  = signed'({4'd0, la, 16'd0}) + lprod + (is_coord ? 36'sd32768 : 36'sd0);
	assign lres  = is_coord ? (lacc[31:16] ^ 16'h8000) : {8'd0, lacc[23:16]};

	// Duplicate check of the interpolated point against both endpoints.
	logic same_a, same_b;
	assign same_a = p_q[0] == prev_x_q && p_q[1] == prev_y_q &&
		p_q[2][7:0] == prev_r_q && p_q[3][7:0] == prev_g_q &&
		p_q[4][7:0] == prev_b_q && p_q[5][7:0] == prev_i_q;
	assign same_b = p_q[0] == cur_q.pos_x && p_q[1] == cur_q.pos_y &&
		p_q[2][7:0] == cur_q.red && p_q[3][7:0] == cur_q.green &&
		p_q[4][7:0] == cur_q.blue && p_q[5][7:0] == cur_q.intensity;

	// Arithmetic registers, updated by command.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lppi_pkg::OP_CAPTURE: cur_q <= in_data;
			lppi_pkg::OP_SQX:     acc_q <= 33'(32'(ax) * 32'(ax));
			lppi_pkg::OP_SQY: begin
				acc_q <= acc_q + 33'(32'(ay) * 32'(ay));
				mm_q  <= 32'(msl_q) * 32'(msl_q);
			end
			lppi_pkg::OP_SQRT_LOAD: begin
				sq_v_q   <= {1'b0, acc_q};
				sq_r_q   <= '0;
				sq_bit_q <= lppi_pkg::SQRT_W'(1) << 32;
			end
			lppi_pkg::OP_SQRT_STEP: begin
				if (sq_v_q >= sq_sum) begin
					sq_v_q <= sq_v_q - sq_sum;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			lppi_pkg::OP_DIV_LOAD_CNT: begin
				quo_q   <= sq_r_q[lppi_pkg::DIV_W-1:0];
				rem_q   <= '0;
				div_d_q <= msl_q;
			end
			lppi_pkg::OP_DIV_STEP: begin
				if (div_ge) begin
					rem_q <= div_sub[15:0];
					quo_q <= {quo_q[lppi_pkg::DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= div_shift[15:0];
					quo_q <= {quo_q[lppi_pkg::DIV_W-2:0], 1'b0};
				end
			end
			lppi_pkg::OP_SET_CNT: begin
				if (quo_q >= lppi_pkg::DIV_W'(lppi_pkg::MAX_INSERT - 1)) begin
					count_q <= lppi_pkg::CNT_W'(lppi_pkg::MAX_INSERT);
				end else begin
					count_q <= quo_q[lppi_pkg::CNT_W-1:0] + lppi_pkg::CNT_W'(1);
				end
			end
			lppi_pkg::OP_DIV_LOAD_T: begin
				quo_q   <= {cmd.pt, 16'd0};
				rem_q   <= '0;
				div_d_q <= 16'({1'b0, count_q} + 7'd1);
			end
			lppi_pkg::OP_EASE1: esq_q <= 32'(u_val) * 32'(u_val);
			lppi_pkg::OP_EASE2: e_q <= e_next;
			lppi_pkg::OP_LERP:  p_q[cmd.field] <= lres;
			default: ;
		endcase
	end

	// Path state: go flag, previous point and whether it was lit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			go_q     <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_r_q <= '0;
			prev_g_q <= '0;
			prev_b_q <= '0;
			prev_i_q <= '0;
		end else if (cmd.op == lppi_pkg::OP_CAPTURE) begin
			go_q <= (|{in_data.red, in_data.green, in_data.blue}) &&
				active_q && !in_data.frame_start && (msl_q != 16'd0);
		end else if (cmd.op == lppi_pkg::OP_EMIT_PASS) begin
			active_q <= |{cur_q.red, cur_q.green, cur_q.blue};
			prev_x_q <= cur_q.pos_x;
			prev_y_q <= cur_q.pos_y;
			prev_r_q <= cur_q.red;
			prev_g_q <= cur_q.green;
			prev_b_q <= cur_q.blue;
			prev_i_q <= cur_q.intensity;
		end
	end

	// Output register: one result transaction held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == lppi_pkg::OP_EMIT_INS || cmd.op == lppi_pkg::OP_EMIT_PASS) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == lppi_pkg::OP_EMIT_INS) begin
			out_q <= '{out_x: p_q[0], out_y: p_q[1], out_red: p_q[2][7:0],
				out_green: p_q[3][7:0], out_blue: p_q[4][7:0],
				out_intensity: p_q[5][7:0], is_inserted: 1'b1, last_of_run: 1'b0};
		end else if (cmd.op == lppi_pkg::OP_EMIT_PASS) begin
			out_q <= '{out_x: cur_q.pos_x, out_y: cur_q.pos_y, out_red: cur_q.red,
				out_green: cur_q.green, out_blue: cur_q.blue,
				out_intensity: cur_q.intensity, is_inserted: 1'b0, last_of_run: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.go        = go_q;
	assign status.gap       = acc_q > {1'b0, mm_q};
	assign status.slot_free = !out_valid_q || out_ready;
	assign status.dup       = same_a || same_b;
	assign status.count     = count_q;

endmodule

### rtl/lppi_ctrl.sv
// Controller state machine of the laser path point interpolator.
// Sequences distance, square root, divisions, easing, interpolation and emission.
// Depends on lppi_pkg.
`timescale 1ns / 1ps

module lppi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lppi_pkg::stat_t status,
	output lppi_pkg::cmd_t  cmd
);

	typedef enum logic [14:0] {
		S_IDLE    = 15'h0001,
		S_SQX     = 15'h0002,
		S_SQY     = 15'h0004,
		S_CMP     = 15'h0008,
		S_SQRT    = 15'h0010,
		S_DIVC_LD = 15'h0020,
		S_DIVC    = 15'h0040,
		S_SETCNT  = 15'h0080,
		S_TLD     = 15'h0100,
		S_TDIV    = 15'h0200,
		S_EASE1   = 15'h0400,
		S_EASE2   = 15'h0800,
		S_LERP    = 15'h1000,
		S_EMIT    = 15'h2000,
		S_PASS    = 15'h4000
	} state_t;

	state_t state_q, state_d;
	logic [lppi_pkg::STEP_W-1:0]  step_q, step_d;
	logic [lppi_pkg::FIELD_W-1:0] field_q, field_d;
	logic [lppi_pkg::CNT_W-1:0]   pt_q, pt_d;
	logic last_pt;

	assign last_pt  = pt_q == status.count;
	assign in_ready = state_q == S_IDLE;

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		field_d   = field_q;
		pt_d      = pt_q;
		cmd.op    = lppi_pkg::OP_NONE;
		cmd.field = field_q;
		cmd.pt    = pt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = lppi_pkg::OP_CAPTURE;
					state_d = S_SQX;
				end
			end
			S_SQX: begin
				cmd.op  = lppi_pkg::OP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op  = lppi_pkg::OP_SQY;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op  = lppi_pkg::OP_SQRT_LOAD;
				step_d  = '0;
				state_d = (status.go && status.gap) ? S_SQRT : S_PASS;
			end
			S_SQRT: begin
				cmd.op = lppi_pkg::OP_SQRT_STEP;
				step_d = step_q + 1'b1;
				if (step_q == lppi_pkg::STEP_W'(lppi_pkg::SQRT_STEPS - 1)) begin
					state_d = S_DIVC_LD;
				end
			end
			S_DIVC_LD: begin
				cmd.op  = lppi_pkg::OP_DIV_LOAD_CNT;
				step_d  = '0;
				state_d = S_DIVC;
			end
			S_DIVC: begin
				cmd.op = lppi_pkg::OP_DIV_STEP;
				step_d = step_q + 1'b1;
				if (step_q == lppi_pkg::STEP_W'(lppi_pkg::DIV_STEPS - 1)) begin
					state_d = S_SETCNT;
				end
			end
			S_SETCNT: begin
				cmd.op  = lppi_pkg::OP_SET_CNT;
				pt_d    = lppi_pkg::CNT_W'(1);
				state_d = S_TLD;
			end
			S_TLD: begin
				cmd.op  = lppi_pkg::OP_DIV_LOAD_T;
				step_d  = '0;
				state_d = S_TDIV;
			end
			S_TDIV: begin
				cmd.op = lppi_pkg::OP_DIV_STEP;
				step_d = step_q + 1'b1;
				if (step_q == lppi_pkg::STEP_W'(lppi_pkg::DIV_STEPS - 1)) begin
					state_d = S_EASE1;
				end
			end
			S_EASE1: begin
				cmd.op  = lppi_pkg::OP_EASE1;
				state_d = S_EASE2;
			end
			S_EASE2: begin
				cmd.op  = lppi_pkg::OP_EASE2;
				field_d = lppi_pkg::FLD_X;
				state_d = S_LERP;
			end
			S_LERP: begin
				cmd.op  = lppi_pkg::OP_LERP;
				field_d = field_q + 1'b1;
				if (field_q == lppi_pkg::FLD_INTENSITY) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				// A duplicate of an endpoint is dropped without a transaction.
				if (status.dup || status.slot_free) begin
					if (!status.dup) begin
						cmd.op = lppi_pkg::OP_EMIT_INS;
					end
					pt_d    = pt_q + 1'b1;
					state_d = last_pt ? S_PASS : S_TLD;
				end
			end
			S_PASS: begin
				if (status.slot_free) begin
					cmd.op  = lppi_pkg::OP_EMIT_PASS;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			field_q <= '0;
			pt_q    <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			field_q <= field_d;
			pt_q    <= pt_d;
		end
	end

	// An emission is only issued into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lppi_pkg::OP_EMIT_INS || cmd.op == lppi_pkg::OP_EMIT_PASS)
		|-> status.slot_free)
		else $error("emission into an occupied output register");

	// The interior point index stays within the saturated insert count.
	a_pt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LERP || state_q == S_EMIT)
		|-> (pt_q != '0 && pt_q <= status.count))
		else $error("interior point index out of range");

	// Emitting the input point ends the run and reopens the input.
	a_pass_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lppi_pkg::OP_EMIT_PASS) |=> (state_q == S_IDLE))
		else $error("run did not end after the input point");

	// A new input is never taken while the run's final result is still unsent.
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lppi_pkg::OP_CAPTURE) |-> $past(state_q) != S_PASS || $past(!arst_n)
		|| $past(cmd.op) == lppi_pkg::OP_EMIT_PASS)
		else $error("input captured before the previous run finished");

endmodule

### rtl/laser_path_point_interpolator.sv
// Top level of the laser path point interpolator.
// Joins the controller (lppi_ctrl) and the datapath (lppi_dp); depends on lppi_pkg.
//
//   Channel   Signals                              Moves
//   input     in_valid, in_ready, in_data          one laser point per transaction
//   output    out_valid, out_ready, out_data       one emitted point per transaction
//   config    cfg_valid, cfg_ready, cfg_index/data register write per transaction
//
// One input is handled at a time. A point that is not interpolated passes capture, the
// two squares and the compare before its output transaction. An interpolated gap adds
// the square root and the count divide, then per interior point the 22-step serial
// divider, two easing multiplies and six single-multiplier field steps. Reset is
// asynchronous, active low, and clears control and path state. A stalled output only
// holds the sequence at an emission; the config port never stalls.
`timescale 1ns / 1ps

module laser_path_point_interpolator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lppi_pkg::point_in_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lppi_pkg::point_out_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	lppi_pkg::cmd_t  cmd;
	lppi_pkg::stat_t status;

	// Sequencer.
	lppi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and storage.
	lppi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
